@@ hdl/rmac_pkg.sv @@
// shared types, register indexes and reset values for the random-access mac node
`default_nettype none

package rmac_pkg;

    localparam int COUNT_WIDTH_DEF = 32;
    localparam int TIME_WIDTH_DEF  = 16;

    localparam int DATA_LEN_W = 12;
    localparam int SLOT_LEN_W = 8;
    localparam int ACK_LEN_W  = 8;
    localparam int OUT_LEN_W  = 8;
    localparam int BO_UNIT_W  = 4;
    localparam int WIN_BASE_W = 6;
    localparam int MAX_RETX_W = 3;
    localparam int CFG_DATA_W = 12;
    localparam int CFG_IDX_W  = 3;

    localparam int RND_W     = 16;
    localparam int ATT_W     = 4;
    localparam int WIN_W     = WIN_BASE_W + ATT_W;
    localparam int DELAY_W   = WIN_W;
    localparam int WAIT_W    = DELAY_W + BO_UNIT_W;
    localparam int DIV_CNT_W = 4;

    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 168;

    localparam logic [CFG_IDX_W-1:0] CFG_DATA_LEN  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOT_LEN  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ACK_LEN   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_LEN   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BO_UNIT   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_WIN_BASE  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_RETX  = 3'd6;

    localparam logic [DATA_LEN_W-1:0] DATA_LEN_RST = 12'd20;
    localparam logic [SLOT_LEN_W-1:0] SLOT_LEN_RST = 8'd2;
    localparam logic [ACK_LEN_W-1:0]  ACK_LEN_RST  = 8'd2;
    localparam logic [OUT_LEN_W-1:0]  OUT_LEN_RST  = 8'd2;
    localparam logic [BO_UNIT_W-1:0]  BO_UNIT_RST  = 4'd2;
    localparam logic [WIN_BASE_W-1:0] WIN_BASE_RST = 6'd11;
    localparam logic [MAX_RETX_W-1:0] MAX_RETX_RST = 3'd3;

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_TX      = 2'd1,
        PH_BACKOFF = 2'd2,
        PH_OUT     = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        EV_NONE      = 2'd0,
        EV_DELIVERED = 2'd1,
        EV_COLLISION = 2'd2,
        EV_DROP      = 2'd3
    } event_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_WIN,
        ST_DIV,
        ST_MUL,
        ST_DRAW,
        ST_FIN
    } seq_state_t;

endpackage

`default_nettype wire

@@ hdl/random_access_mac_node_core.sv @@
// random-access mac node: tick stepper with a bit-serial modulo unit
//
// channel  direction  handshake           payload
// s        in         s_tvalid/s_tready   s_tdata: random_word, others_transmitting
// m        out        m_tvalid/m_tready   m_tdata: state, event, times, attempt, counters
// cfg      in         cfg_wr_en           cfg_index, cfg_wr_data
//
// a tick without a backoff draw passes accept, evaluate and hand over (idle, eval, fin)
// a tick with a backoff draw adds window, 16-step restoring modulo, multiply and draw
// a draw with a window of 0 or 1 skips the modulo and the multiply
// the finished result sits in the output register while the next transaction is taken
// reset clears control state and loads the register defaults
// a stalled output holds the sequencer in its final state until the register frees up
`default_nettype none

module random_access_mac_node_core #(
    parameter int COUNT_WIDTH = rmac_pkg::COUNT_WIDTH_DEF,
    parameter int TIME_WIDTH  = rmac_pkg::TIME_WIDTH_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    // random_word[15:0], others_transmitting[16], zero pad
    input  wire logic [rmac_pkg::IN_DATA_W-1:0]      s_tdata,
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // node_state[1:0], cycle_event[3:2], cycle_time[19:4], air_time[35:20],
    // attempt_now[39:36], first_sends[71:40], deliveries[103:72],
    // collisions[135:104], drops[167:136]
    output logic [rmac_pkg::OUT_DATA_W-1:0]          m_tdata,
    input  wire logic                                cfg_wr_en,
    input  wire logic [rmac_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [rmac_pkg::CFG_DATA_W-1:0]     cfg_wr_data
);

    localparam int TW = TIME_WIDTH;
    localparam int CW = COUNT_WIDTH;
    localparam int XW = rmac_pkg::WAIT_W;
    localparam int MW = (TW > XW) ? TW : XW;
    localparam int DW = rmac_pkg::DELAY_W;
    localparam int AW = rmac_pkg::ATT_W;
    localparam int RW = rmac_pkg::RND_W;
    localparam logic [TW-1:0] TIME_MAX = {TW{1'b1}};

    function automatic logic [TW-1:0] sat_add(input logic [TW-1:0] a, input logic [XW-1:0] b);
        logic [MW:0] s;
        s = {{(MW+1-TW){1'b0}}, a} + {{(MW+1-XW){1'b0}}, b};
        if (s > {{(MW+1-TW){1'b0}}, TIME_MAX})
            return TIME_MAX;
        return s[TW-1:0];
    endfunction

    function automatic logic [TW-1:0] wait_ticks(input logic [XW-1:0] x);
        logic [MW:0] t;
        t = {{(MW+1-XW){1'b0}}, x} - {{MW{1'b0}}, 1'b1};
        if (t > {{(MW+1-TW){1'b0}}, TIME_MAX})
            return TIME_MAX;
        return t[TW-1:0];
    endfunction

    function automatic logic [XW-1:0] max1(input logic [XW-1:0] x);
        return (x == '0) ? {{(XW-1){1'b0}}, 1'b1} : x;
    endfunction

    function automatic logic [15:0] time_out(input logic [TW-1:0] v);
        logic [TW+15:0] e;
        e = {16'b0, v};
        return e[15:0];
    endfunction

    function automatic logic [31:0] cnt_out(input logic [CW-1:0] v);
        logic [CW+31:0] e;
        e = {32'b0, v};
        return e[31:0];
    endfunction

    // configuration
    logic [rmac_pkg::DATA_LEN_W-1:0] data_len_reg;
    logic [rmac_pkg::SLOT_LEN_W-1:0] slot_len_reg;
    logic [rmac_pkg::ACK_LEN_W-1:0]  ack_len_reg;
    logic [rmac_pkg::OUT_LEN_W-1:0]  out_len_reg;
    logic [rmac_pkg::BO_UNIT_W-1:0]  bo_unit_reg;
    logic [rmac_pkg::WIN_BASE_W-1:0] win_base_reg;
    logic [rmac_pkg::MAX_RETX_W-1:0] max_retx_reg;

    // node state
    rmac_pkg::seq_state_t state_reg, state_next;
    rmac_pkg::phase_t     phase_reg, phase_next;
    rmac_pkg::event_t     ev_reg, ev_next;
    logic [TW-1:0]        ticks_reg, ticks_next;
    logic [AW-1:0]        attempts_reg, attempts_next;
    logic                 collided_reg, collided_next;
    logic [TW-1:0]        cycle_reg, cycle_next;
    logic [TW-1:0]        air_reg, air_next;
    logic [TW-1:0]        ct_reg, ct_next;
    logic [TW-1:0]        at_reg, at_next;
    logic [CW-1:0]        sent_reg, sent_next;
    logic [CW-1:0]        ok_reg, ok_next;
    logic [CW-1:0]        coll_reg, coll_next;
    logic [CW-1:0]        drop_reg, drop_next;
    logic                 first_reg, first_next;
    logic [rmac_pkg::DIV_CNT_W-1:0] div_cnt_reg, div_cnt_next;
    logic                 m_tvalid_reg, m_tvalid_next;

    // payload
    logic [RW-1:0]        rnd_reg;
    logic                 others_reg;
    logic [RW-1:0]        dvd_reg, dvd_next;
    logic [DW-1:0]        dv_reg, dv_next;
    logic [DW-1:0]        rem_reg, rem_next;
    logic [XW-1:0]        prod_reg, prod_next;
    logic [rmac_pkg::OUT_DATA_W-1:0] m_tdata_reg, m_tdata_next;

    logic [AW-1:0]        att_inc;
    logic                 retry_ok;
    logic                 need_draw;
    logic [DW-1:0]        win;
    logic [DW:0]          trial;
    logic [XW-1:0]        d_frame;
    logic [XW-1:0]        x_ack;
    logic [XW-1:0]        x_out;
    logic [XW-1:0]        x_slot;
    logic                 out_free;
    logic                 s_fire;

    assign att_inc   = attempts_reg + {{(AW-1){1'b0}}, 1'b1};
    assign retry_ok  = ({1'b0, att_inc} <= ({2'b0, max_retx_reg} + 5'd1));
    assign need_draw = (ticks_reg == '0) && ((phase_reg == rmac_pkg::PH_IDLE) ||
                       ((phase_reg == rmac_pkg::PH_OUT) && retry_ok));
    assign win       = DW'(win_base_reg) * DW'(attempts_reg);
    assign trial     = {rem_reg, dvd_reg[RW-1]};
    assign d_frame   = max1(XW'(data_len_reg));
    assign x_ack     = max1(XW'(ack_len_reg) + XW'(slot_len_reg));
    assign x_out     = max1(XW'(out_len_reg));
    assign x_slot    = max1(XW'(slot_len_reg));
    assign out_free  = !m_tvalid_reg || m_tready;
    assign s_fire    = s_tvalid && s_tready;

    // outputs
    always_comb
    begin
        s_tready = (state_reg == rmac_pkg::ST_IDLE);
        m_tvalid = m_tvalid_reg;
        m_tdata  = m_tdata_reg;
    end

    // sequencer next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            rmac_pkg::ST_IDLE:
            begin
                if (s_fire)
                    state_next = rmac_pkg::ST_EVAL;
            end
            rmac_pkg::ST_EVAL:
            begin
                state_next = need_draw ? rmac_pkg::ST_WIN : rmac_pkg::ST_FIN;
            end
            rmac_pkg::ST_WIN:
            begin
                state_next = (win <= DW'(1)) ? rmac_pkg::ST_DRAW : rmac_pkg::ST_DIV;
            end
            rmac_pkg::ST_DIV:
            begin
                if (div_cnt_reg == {rmac_pkg::DIV_CNT_W{1'b1}})
                    state_next = rmac_pkg::ST_MUL;
            end
            rmac_pkg::ST_MUL:  state_next = rmac_pkg::ST_DRAW;
            rmac_pkg::ST_DRAW: state_next = rmac_pkg::ST_FIN;
            rmac_pkg::ST_FIN:
            begin
                if (out_free)
                    state_next = rmac_pkg::ST_IDLE;
            end
            default: state_next = rmac_pkg::ST_IDLE;
        endcase
    end

    // datapath
    always_comb
    begin
        phase_next    = phase_reg;
        ev_next       = ev_reg;
        ticks_next    = ticks_reg;
        attempts_next = attempts_reg;
        collided_next = collided_reg;
        cycle_next    = cycle_reg;
        air_next      = air_reg;
        ct_next       = ct_reg;
        at_next       = at_reg;
        sent_next     = sent_reg;
        ok_next       = ok_reg;
        coll_next     = coll_reg;
        drop_next     = drop_reg;
        first_next    = first_reg;
        div_cnt_next  = div_cnt_reg;
        dvd_next      = dvd_reg;
        dv_next       = dv_reg;
        rem_next      = rem_reg;
        prod_next     = prod_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;

        if (m_tvalid_reg && m_tready)
            m_tvalid_next = 1'b0;

        unique case (state_reg)
            rmac_pkg::ST_EVAL:
            begin
                ev_next = rmac_pkg::EV_NONE;
                ct_next = '0;
                at_next = '0;
                if (ticks_reg != '0)
                begin
                    ticks_next = ticks_reg - {{(TW-1){1'b0}}, 1'b1};
                    if (phase_reg == rmac_pkg::PH_TX)
                        collided_next = collided_reg | others_reg;
                end
                else
                begin
                    unique case (phase_reg)
                        rmac_pkg::PH_IDLE:
                        begin
                            attempts_next = att_inc;
                            first_next    = 1'b1;
                        end
                        rmac_pkg::PH_TX:
                        begin
                            if (!collided_reg)
                            begin
                                ev_next       = rmac_pkg::EV_DELIVERED;
                                ct_next       = sat_add(cycle_reg, x_ack);
                                at_next       = air_reg;
                                cycle_next    = '0;
                                air_next      = '0;
                                ok_next       = ok_reg + {{(CW-1){1'b0}}, 1'b1};
                                phase_next    = rmac_pkg::PH_IDLE;
                                ticks_next    = wait_ticks(x_ack);
                                attempts_next = '0;
                            end
                            else
                            begin
                                phase_next = rmac_pkg::PH_OUT;
                                ticks_next = wait_ticks(x_out);
                                cycle_next = sat_add(cycle_reg, x_out);
                            end
                        end
                        rmac_pkg::PH_BACKOFF:
                        begin
                            phase_next    = rmac_pkg::PH_TX;
                            collided_next = 1'b0;
                            ticks_next    = wait_ticks(d_frame);
                            air_next      = sat_add(air_reg, d_frame);
                            cycle_next    = sat_add(cycle_reg, d_frame);
                            if (attempts_reg == {{(AW-1){1'b0}}, 1'b1})
                                sent_next = sent_reg + {{(CW-1){1'b0}}, 1'b1};
                        end
                        rmac_pkg::PH_OUT:
                        begin
                            attempts_next = att_inc;
                            coll_next     = coll_reg + {{(CW-1){1'b0}}, 1'b1};
                            if (retry_ok)
                            begin
                                ev_next    = rmac_pkg::EV_COLLISION;
                                first_next = 1'b0;
                            end
                            else
                            begin
                                ev_next       = rmac_pkg::EV_DROP;
                                ct_next       = sat_add(cycle_reg, x_slot);
                                at_next       = air_reg;
                                cycle_next    = '0;
                                air_next      = '0;
                                drop_next     = drop_reg + {{(CW-1){1'b0}}, 1'b1};
                                phase_next    = rmac_pkg::PH_IDLE;
                                ticks_next    = wait_ticks(x_slot);
                                attempts_next = '0;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            rmac_pkg::ST_WIN:
            begin
                dv_next      = win - DW'(1);
                rem_next     = '0;
                dvd_next     = rnd_reg;
                div_cnt_next = '0;
            end
            rmac_pkg::ST_DIV:
            begin
                // restoring modulo, one dividend bit per cycle
                if (trial >= {1'b0, dv_reg})
                    rem_next = DW'(trial - {1'b0, dv_reg});
                else
                    rem_next = trial[DW-1:0];
                dvd_next     = {dvd_reg[RW-2:0], 1'b0};
                div_cnt_next = div_cnt_reg + {{(rmac_pkg::DIV_CNT_W-1){1'b0}}, 1'b1};
            end
            rmac_pkg::ST_MUL:
            begin
                prod_next = XW'(rem_reg) * XW'(bo_unit_reg);
            end
            rmac_pkg::ST_DRAW:
            begin
                if (rem_reg == '0)
                begin
                    phase_next    = rmac_pkg::PH_TX;
                    collided_next = 1'b0;
                    ticks_next    = wait_ticks(d_frame);
                    air_next      = sat_add(air_reg, d_frame);
                    cycle_next    = sat_add(cycle_reg, d_frame);
                    if (first_reg)
                        sent_next = sent_reg + {{(CW-1){1'b0}}, 1'b1};
                end
                else
                begin
                    phase_next = rmac_pkg::PH_BACKOFF;
                    ticks_next = wait_ticks(max1(prod_reg));
                    cycle_next = sat_add(cycle_reg, max1(prod_reg));
                end
            end
            rmac_pkg::ST_FIN:
            begin
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {cnt_out(drop_reg), cnt_out(coll_reg),
                                     cnt_out(ok_reg), cnt_out(sent_reg),
                                     attempts_reg, time_out(at_reg), time_out(ct_reg),
                                     ev_reg, phase_reg};
                end
            end
            default: ;
        endcase
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_len_reg <= rmac_pkg::DATA_LEN_RST;
            slot_len_reg <= rmac_pkg::SLOT_LEN_RST;
            ack_len_reg  <= rmac_pkg::ACK_LEN_RST;
            out_len_reg  <= rmac_pkg::OUT_LEN_RST;
            bo_unit_reg  <= rmac_pkg::BO_UNIT_RST;
            win_base_reg <= rmac_pkg::WIN_BASE_RST;
            max_retx_reg <= rmac_pkg::MAX_RETX_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                rmac_pkg::CFG_DATA_LEN: data_len_reg <= cfg_wr_data;
                rmac_pkg::CFG_SLOT_LEN: slot_len_reg <= cfg_wr_data[rmac_pkg::SLOT_LEN_W-1:0];
                rmac_pkg::CFG_ACK_LEN:  ack_len_reg  <= cfg_wr_data[rmac_pkg::ACK_LEN_W-1:0];
                rmac_pkg::CFG_OUT_LEN:  out_len_reg  <= cfg_wr_data[rmac_pkg::OUT_LEN_W-1:0];
                rmac_pkg::CFG_BO_UNIT:  bo_unit_reg  <= cfg_wr_data[rmac_pkg::BO_UNIT_W-1:0];
                rmac_pkg::CFG_WIN_BASE: win_base_reg <= cfg_wr_data[rmac_pkg::WIN_BASE_W-1:0];
                rmac_pkg::CFG_MAX_RETX: max_retx_reg <= cfg_wr_data[rmac_pkg::MAX_RETX_W-1:0];
                default: ;
            endcase
        end
    end

    // control and node state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= rmac_pkg::ST_IDLE;
            phase_reg    <= rmac_pkg::PH_IDLE;
            ev_reg       <= rmac_pkg::EV_NONE;
            ticks_reg    <= TW'(rmac_pkg::SLOT_LEN_RST);
            attempts_reg <= '0;
            collided_reg <= 1'b0;
            cycle_reg    <= TW'(rmac_pkg::SLOT_LEN_RST);
            air_reg      <= '0;
            ct_reg       <= '0;
            at_reg       <= '0;
            sent_reg     <= '0;
            ok_reg       <= '0;
            coll_reg     <= '0;
            drop_reg     <= '0;
            first_reg    <= 1'b0;
            div_cnt_reg  <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            phase_reg    <= phase_next;
            ev_reg       <= ev_next;
            ticks_reg    <= ticks_next;
            attempts_reg <= attempts_next;
            collided_reg <= collided_next;
            cycle_reg    <= cycle_next;
            air_reg      <= air_next;
            ct_reg       <= ct_next;
            at_reg       <= at_next;
            sent_reg     <= sent_next;
            ok_reg       <= ok_next;
            coll_reg     <= coll_next;
            drop_reg     <= drop_next;
            first_reg    <= first_next;
            div_cnt_reg  <= div_cnt_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            rnd_reg    <= s_tdata[RW-1:0];
            others_reg <= s_tdata[RW];
        end
        dvd_reg     <= dvd_next;
        dv_reg      <= dv_next;
        rem_reg     <= rem_next;
        prod_reg    <= prod_next;
        m_tdata_reg <= m_tdata_next;
    end

endmodule

`default_nettype wire
